/* rtl/core/vgmp_pkg.sv */
// shared types, event codes and command decode for the vgm command stream parser
`default_nettype none

package vgmp_pkg;

  localparam int EvtW  = 3;
  localparam int OpsW  = 48;
  localparam int WordW = 32;

  localparam logic [EvtW-1:0] EV_AY       = 3'd0;
  localparam logic [EvtW-1:0] EV_APU      = 3'd1;
  localparam logic [EvtW-1:0] EV_WAIT     = 3'd2;
  localparam logic [EvtW-1:0] EV_LOOP     = 3'd3;
  localparam logic [EvtW-1:0] EV_END      = 3'd4;
  localparam logic [EvtW-1:0] EV_UNKNOWN  = 3'd5;
  localparam logic [EvtW-1:0] EV_DURATION = 3'd6;
  localparam logic [EvtW-1:0] EV_BLOCK    = 3'd7;

  localparam logic [7:0] CMD_WAIT_N    = 8'h61;
  localparam logic [7:0] CMD_WAIT_735  = 8'h62;
  localparam logic [7:0] CMD_WAIT_882  = 8'h63;
  localparam logic [7:0] CMD_END       = 8'h66;
  localparam logic [7:0] CMD_BLOCK     = 8'h67;
  localparam logic [7:0] CMD_AY_WRITE  = 8'hA0;
  localparam logic [7:0] CMD_APU_WRITE = 8'hB4;
  localparam logic [3:0] CMD_WAIT_SHORT_HI = 4'h7;

  localparam logic [15:0] WAIT_735 = 16'd735;
  localparam logic [15:0] WAIT_882 = 16'd882;

  localparam logic [1:0] REG_LOOP_OFFSET = 2'd0;
  localparam logic [1:0] REG_PLAY_COUNT  = 2'd1;
  localparam logic [1:0] REG_MAX_SAMPLES = 2'd2;

  localparam logic [31:0] LOOP_OFFSET_RST = 32'd0;
  localparam logic [7:0]  PLAY_COUNT_RST  = 8'd2;
  localparam logic [31:0] MAX_SAMPLES_RST = 32'd7938000;

  typedef struct packed {
    logic [31:0] loop_offset;
    logic [7:0]  play_count;
    logic [31:0] max_samples;
  } cfg_t;

  typedef struct packed {
    logic [31:0]     offset_or_length;
    logic [7:0]      block_type;
    logic [15:0]     wait_count;
    logic [7:0]      reg_value;
    logic [7:0]      reg_addr;
    logic [EvtW-1:0] event_kind;
  } evt_t;

  typedef struct packed {
    logic       known;
    logic [2:0] len;
  } op_len_t;

  function automatic op_len_t operand_len(input logic [7:0] c);
    op_len_t r;
    r.known = 1'b1;
    r.len   = 3'd0;
    if (c < 8'h30) begin
      r.known = 1'b0;
    end else if (c <= 8'h3F) begin
      r.len = 3'd1;
    end else if (c <= 8'h4E) begin
      r.len = 3'd2;
    end else if (c <= 8'h50) begin
      r.len = 3'd1;
    end else if (c <= 8'h5F) begin
      r.len = 3'd2;
    end else if (c == CMD_WAIT_N) begin
      r.len = 3'd2;
    end else if (c == CMD_WAIT_735 || c == CMD_WAIT_882 || c == CMD_END) begin
      r.len = 3'd0;
    end else if (c == CMD_BLOCK) begin
      r.len = 3'd6;
    end else if (c < 8'h70) begin
      r.known = 1'b0;
    end else if (c <= 8'h8F) begin
      r.len = 3'd0;
    end else if (c < 8'hA0) begin
      r.known = 1'b0;
    end else if (c <= 8'hBF) begin
      r.len = 3'd2;
    end else if (c <= 8'hDF) begin
      r.len = 3'd3;
    end else begin
      r.len = 3'd4;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/vgmp_core.sv */
// parser state and per-item event decode
`default_nettype none

module vgmp_core
  import vgmp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_accept,
  input  wire logic [7:0] byte_in,
  input  wire cfg_t       cfg,
  output logic            evt_valid,
  output evt_t            evt
);

  logic [7:0]      command_code, command_code_next;
  logic [2:0]      bytes_left, bytes_left_next;
  logic [2:0]      op_idx, op_idx_next;
  logic [OpsW-1:0] operand_bytes, operand_bytes_next;
  logic [31:0]     payload_skip, payload_skip_next;
  logic [7:0]      ends_seen, ends_seen_next;
  logic [31:0]     samples_played, samples_played_next;
  logic            halted, halted_next;

  logic            do_finish;
  logic [7:0]      fin_code;
  logic [OpsW-1:0] fin_ops;
  logic [OpsW-1:0] byte_shifted;
  logic [32:0]     wait_sum;
  logic [15:0]     wait_n;
  logic            is_wait;
  op_len_t         lut;

  always_comb begin
    command_code_next   = command_code;
    bytes_left_next     = bytes_left;
    op_idx_next         = op_idx;
    operand_bytes_next  = operand_bytes;
    payload_skip_next   = payload_skip;
    ends_seen_next      = ends_seen;
    samples_played_next = samples_played;
    halted_next         = halted;
    evt_valid           = 1'b0;
    evt                 = '0;
    do_finish           = 1'b0;
    fin_code            = command_code;
    fin_ops             = operand_bytes;
    is_wait             = 1'b0;
    wait_n              = 16'd0;
    lut                 = operand_len(byte_in);
    byte_shifted        = '0;
    wait_sum            = '0;

    case (op_idx)
      3'd0:    byte_shifted = {40'd0, byte_in};
      3'd1:    byte_shifted = {32'd0, byte_in, 8'd0};
      3'd2:    byte_shifted = {24'd0, byte_in, 16'd0};
      3'd3:    byte_shifted = {16'd0, byte_in, 24'd0};
      3'd4:    byte_shifted = {8'd0, byte_in, 32'd0};
      3'd5:    byte_shifted = {byte_in, 40'd0};
      default: byte_shifted = '0;
    endcase

    if (byte_accept && !halted) begin
      if (payload_skip != 32'd0) begin
        payload_skip_next = payload_skip - 32'd1;
      end else if (bytes_left != 3'd0) begin
        operand_bytes_next = operand_bytes | byte_shifted;
        bytes_left_next    = bytes_left - 3'd1;
        op_idx_next        = op_idx + 3'd1;
        if (bytes_left == 3'd1) begin
          do_finish = 1'b1;
          fin_ops   = operand_bytes_next;
        end
      end else if (cfg.max_samples != 32'd0 && samples_played >= cfg.max_samples) begin
        halted_next      = 1'b1;
        evt_valid        = 1'b1;
        evt.event_kind   = EV_DURATION;
      end else begin
        command_code_next  = byte_in;
        operand_bytes_next = '0;
        op_idx_next        = 3'd0;
        if (!lut.known) begin
          halted_next    = 1'b1;
          evt_valid      = 1'b1;
          evt.event_kind = EV_UNKNOWN;
        end else if (lut.len == 3'd0) begin
          do_finish = 1'b1;
          fin_code  = byte_in;
          fin_ops   = '0;
        end else begin
          bytes_left_next = lut.len;
        end
      end
    end

    if (do_finish) begin
      if (fin_code == CMD_AY_WRITE || fin_code == CMD_APU_WRITE) begin
        evt_valid      = 1'b1;
        evt.event_kind = (fin_code == CMD_AY_WRITE) ? EV_AY : EV_APU;
        evt.reg_addr   = fin_ops[7:0];
        evt.reg_value  = fin_ops[15:8];
      end else if (fin_code == CMD_WAIT_N) begin
        is_wait = 1'b1;
        wait_n  = fin_ops[15:0];
      end else if (fin_code == CMD_WAIT_735) begin
        is_wait = 1'b1;
        wait_n  = WAIT_735;
      end else if (fin_code == CMD_WAIT_882) begin
        is_wait = 1'b1;
        wait_n  = WAIT_882;
      end else if (fin_code[7:4] == CMD_WAIT_SHORT_HI) begin
        is_wait = 1'b1;
        wait_n  = {12'd0, fin_code[3:0]} + 16'd1;
      end else if (fin_code == CMD_END) begin
        evt_valid = 1'b1;
        if (cfg.loop_offset != 32'd0 &&
            (cfg.play_count == 8'd0 ||
             ({1'b0, ends_seen} + 9'd1) < {1'b0, cfg.play_count})) begin
          if (ends_seen != 8'hFF) begin
            ends_seen_next = ends_seen + 8'd1;
          end
          evt.event_kind       = EV_LOOP;
          evt.offset_or_length = cfg.loop_offset;
        end else begin
          halted_next    = 1'b1;
          evt.event_kind = EV_END;
        end
      end else if (fin_code == CMD_BLOCK) begin
        payload_skip_next    = fin_ops[47:16];
        evt_valid            = 1'b1;
        evt.event_kind       = EV_BLOCK;
        evt.block_type       = fin_ops[15:8];
        evt.offset_or_length = fin_ops[47:16];
      end
    end

    if (is_wait) begin
      wait_sum            = {1'b0, samples_played} + {17'd0, wait_n};
      samples_played_next = wait_sum[32] ? 32'hFFFF_FFFF : wait_sum[31:0];
      evt_valid           = 1'b1;
      evt.event_kind      = EV_WAIT;
      evt.wait_count      = wait_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_code   <= 8'd0;
      bytes_left     <= 3'd0;
      op_idx         <= 3'd0;
      operand_bytes  <= '0;
      payload_skip   <= 32'd0;
      ends_seen      <= 8'd0;
      samples_played <= 32'd0;
      halted         <= 1'b0;
    end else begin
      command_code   <= command_code_next;
      bytes_left     <= bytes_left_next;
      op_idx         <= op_idx_next;
      operand_bytes  <= operand_bytes_next;
      payload_skip   <= payload_skip_next;
      ends_seen      <= ends_seen_next;
      samples_played <= samples_played_next;
      halted         <= halted_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/vgm_command_stream_parser_top.sv */
// top level of the vgm command stream parser: config registers and event output register
`default_nettype none

// Takes one byte of a VGM command stream per item and gives at most one event per
// byte. A byte is taken in every cycle in which the output register is empty or is
// being emptied, so the sustained rate is one byte per clock; each byte is decoded in
// the cycle it is accepted and its event appears in the output register on the next
// cycle. The parser stops after an end, unknown command or duration event and then
// drops all bytes until reset. Configuration writes are registered and apply to later bytes.

module vgm_command_stream_parser_top
  import vgmp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // stream_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // event_kind, reg_addr, reg_value, wait_count, block_type, offset_or_length, zero pad
  output logic [79:0]      m_axis_tdata,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wr_data
);

  cfg_t  cfg;
  logic  in_accept;
  logic  evt_valid;
  evt_t  evt;
  evt_t  out_evt;
  logic  out_valid;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_evt};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.loop_offset <= LOOP_OFFSET_RST;
      cfg.play_count  <= PLAY_COUNT_RST;
      cfg.max_samples <= MAX_SAMPLES_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LOOP_OFFSET: cfg.loop_offset <= cfg_wr_data;
        REG_PLAY_COUNT:  cfg.play_count  <= cfg_wr_data[7:0];
        REG_MAX_SAMPLES: cfg.max_samples <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  vgmp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .byte_accept (in_accept),
    .byte_in     (s_axis_tdata),
    .cfg         (cfg),
    .evt_valid   (evt_valid),
    .evt         (evt)
  );

  // output register, reloaded as the previous item leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && evt_valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && evt_valid) begin
      out_evt <= evt;
    end
  end

endmodule

`default_nettype wire

/* tb/tb_vgm_command_stream_parser_top.sv */
// self-checking testbench for the vgm command stream parser top level
module tb_vgm_command_stream_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vgmp_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 310;
  localparam int MAX_REPORTS = 40;
  localparam logic [7:0] CMD_DAC_WAIT_15 = 8'h8F;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [79:0] m_data;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_wr_data = '0;

  logic [7:0] stream_q[$];
  evt_t       event_q[$];

  int errors = 0;
  int cycles = 0;
  int fed_total = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  // parser state as predicted
  logic [7:0]  cur_cmd = '0;
  logic [2:0]  ops_due = '0;
  logic [47:0] ops_seen = '0;
  logic [31:0] skip_due = '0;
  logic [7:0]  loops_taken = '0;
  logic [31:0] samples_total = '0;
  bit          parser_stopped = 1'b0;

  logic [31:0] loop_ofs = LOOP_OFFSET_RST;
  logic [7:0]  pass_limit = PLAY_COUNT_RST;
  logic [31:0] sample_limit = MAX_SAMPLES_RST;

  vgm_command_stream_parser_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wr_data   (cfg_wr_data)
  );

  always #2 clk = ~clk;

  function automatic int cmd_len(input logic [7:0] c);
    case (c[7:4])
      4'h0, 4'h1, 4'h2, 4'h9: return -1;
      4'h3: return 1;
      4'h4: return (c[3:0] == 4'hF) ? 1 : 2;
      4'h5: return (c[3:0] == 4'h0) ? 1 : 2;
      4'h6: begin
        if (c == CMD_WAIT_N) return 2;
        if (c == CMD_WAIT_735 || c == CMD_WAIT_882 || c == CMD_END) return 0;
        if (c == CMD_BLOCK) return 6;
        return -1;
      end
      4'h7, 4'h8: return 0;
      4'hA, 4'hB: return 2;
      4'hC, 4'hD: return 3;
      default: return 4;
    endcase
  endfunction

  function automatic bit loop_due();
    return loop_ofs != 32'd0 &&
           (pass_limit == 8'd0 || ({1'b0, loops_taken} + 9'd1) < {1'b0, pass_limit});
  endfunction

  function automatic bit wait_fits(input logic [15:0] amount);
    return sample_limit == 32'd0 ||
           ({1'b0, samples_total} + {17'd0, amount}) < {1'b0, sample_limit};
  endfunction

  function automatic bit complete_cmd(output evt_t ev);
    logic [15:0] amount;
    logic [32:0] sum;
    bit is_wait;
    ev = '0;
    amount = '0;
    is_wait = 1'b0;
    if (cur_cmd == CMD_AY_WRITE || cur_cmd == CMD_APU_WRITE) begin
      ev.event_kind = (cur_cmd == CMD_AY_WRITE) ? EV_AY : EV_APU;
      ev.reg_addr = ops_seen[7:0];
      ev.reg_value = ops_seen[15:8];
      return 1'b1;
    end
    if (cur_cmd == CMD_END) begin
      if (loop_due()) begin
        if (loops_taken != 8'hFF) loops_taken++;
        ev.event_kind = EV_LOOP;
        ev.offset_or_length = loop_ofs;
      end else begin
        parser_stopped = 1'b1;
        ev.event_kind = EV_END;
      end
      return 1'b1;
    end
    if (cur_cmd == CMD_BLOCK) begin
      skip_due = ops_seen[47:16];
      ev.event_kind = EV_BLOCK;
      ev.block_type = ops_seen[15:8];
      ev.offset_or_length = ops_seen[47:16];
      return 1'b1;
    end
    if (cur_cmd == CMD_WAIT_N) begin
      is_wait = 1'b1;
      amount = ops_seen[15:0];
    end else if (cur_cmd == CMD_WAIT_735) begin
      is_wait = 1'b1;
      amount = WAIT_735;
    end else if (cur_cmd == CMD_WAIT_882) begin
      is_wait = 1'b1;
      amount = WAIT_882;
    end else if (cur_cmd[7:4] == CMD_WAIT_SHORT_HI) begin
      is_wait = 1'b1;
      amount = {12'd0, cur_cmd[3:0]} + 16'd1;
    end
    if (!is_wait) return 1'b0;
    sum = {1'b0, samples_total} + {17'd0, amount};
    samples_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    ev.event_kind = EV_WAIT;
    ev.wait_count = amount;
    return 1'b1;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output evt_t ev);
    int total;
    int idx;
    ev = '0;
    if (parser_stopped) return 1'b0;
    if (skip_due != 32'd0) begin
      skip_due--;
      return 1'b0;
    end
    if (ops_due != 3'd0) begin
      total = cmd_len(cur_cmd);
      idx = total - int'(ops_due);
      ops_seen[idx*8 +: 8] = b;
      ops_due--;
      if (ops_due == 3'd0) return complete_cmd(ev);
      return 1'b0;
    end
    if (sample_limit != 32'd0 && samples_total >= sample_limit) begin
      parser_stopped = 1'b1;
      ev.event_kind = EV_DURATION;
      return 1'b1;
    end
    cur_cmd = b;
    ops_seen = '0;
    total = cmd_len(b);
    if (total < 0) begin
      parser_stopped = 1'b1;
      ev.event_kind = EV_UNKNOWN;
      return 1'b1;
    end
    if (total == 0) return complete_cmd(ev);
    ops_due = 3'(total);
    return 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic feed(input logic [7:0] b);
    evt_t ev;
    if (parse_byte(b, ev)) event_q.push_back(ev);
    stream_q.push_back(b);
    fed_total++;
  endtask

  task automatic feed_cmd(input logic [7:0] code);
    int n;
    n = cmd_len(code);
    feed(code);
    repeat (n) feed(8'($urandom_range(0, 255)));
  endtask

  // any known command that neither waits, ends nor opens a data block
  task automatic feed_other();
    logic [7:0] code;
    do begin
      code = 8'($urandom_range(0, 255));
    end while (cmd_len(code) < 0 || code[7:4] == CMD_WAIT_SHORT_HI ||
               code == CMD_WAIT_N || code == CMD_WAIT_735 || code == CMD_WAIT_882 ||
               code == CMD_END || code == CMD_BLOCK);
    feed_cmd(code);
  endtask

  task automatic feed_block();
    logic [31:0] len;
    int r;
    r = $urandom_range(0, 39);
    if (r < 30) len = $urandom_range(0, 6);
    else if (r < 38) len = $urandom_range(7, 40);
    else len = $urandom_range(41, 300);
    feed(CMD_BLOCK);
    feed(8'($urandom_range(0, 255)));
    feed(8'($urandom_range(0, 255)));
    for (int i = 0; i < 4; i++) feed(len[8*i +: 8]);
    repeat (len) feed(8'($urandom_range(0, 255)));
  endtask

  // one whole command that keeps the parser running
  task automatic gen_command();
    int pick;
    logic [15:0] amount;
    pick = $urandom_range(0, 99);
    if (pick < 14) begin
      feed_cmd(CMD_AY_WRITE);
    end else if (pick < 26) begin
      feed_cmd(CMD_APU_WRITE);
    end else if (pick < 36) begin
      amount = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 15))
                                            : 16'($urandom_range(0, 65535));
      if (wait_fits(amount)) begin
        feed(CMD_WAIT_N);
        feed(amount[7:0]);
        feed(amount[15:8]);
      end else begin
        feed_other();
      end
    end else if (pick < 42) begin
      if (wait_fits(WAIT_735)) feed(CMD_WAIT_735);
      else feed_other();
    end else if (pick < 48) begin
      if (wait_fits(WAIT_882)) feed(CMD_WAIT_882);
      else feed_other();
    end else if (pick < 62) begin
      amount = 16'($urandom_range(1, 16));
      if (wait_fits(amount)) feed({CMD_WAIT_SHORT_HI, 4'(amount - 16'd1)});
      else feed_other();
    end else if (pick < 69) begin
      if (loop_due()) feed(CMD_END);
      else feed_other();
    end else if (pick < 76) begin
      feed_block();
    end else begin
      feed_other();
    end
  endtask

  task automatic settle();
    while (stream_q.size() != 0 || s_valid || event_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_LOOP_OFFSET: loop_ofs = val;
      REG_PLAY_COUNT:  pass_limit = val[7:0];
      REG_MAX_SAMPLES: sample_limit = val;
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [31:0] lo, input logic [7:0] pc,
                           input logic [31:0] ms, input bit long_hold);
    int start;
    settle();
    write_reg(REG_LOOP_OFFSET, lo);
    write_reg(REG_PLAY_COUNT, {24'd0, pc});
    write_reg(REG_MAX_SAMPLES, ms);
    quiet = ($urandom_range(0, 2) == 0);
    start = fed_total;
    while (fed_total - start < PHASE_ITEMS) gen_command();
    if (long_hold) hold_req = 1'b1;
  endtask

  task automatic note(input string fname, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: %s expected %0h actual %0h", $time, fname, want, got);
    end
  endtask

  task automatic check_event(input logic [79:0] raw);
    evt_t got;
    evt_t want;
    got = raw[74:0];
    note("padding", 32'd0, {27'd0, raw[79:75]});
    if (event_q.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: event expected none actual %h", $time, raw);
    end else begin
      want = event_q.pop_front();
      note("event_kind", 32'(want.event_kind), 32'(got.event_kind));
      note("reg_addr", 32'(want.reg_addr), 32'(got.reg_addr));
      note("reg_value", 32'(want.reg_value), 32'(got.reg_value));
      note("wait_count", 32'(want.wait_count), 32'(got.wait_count));
      note("block_type", 32'(want.block_type), 32'(got.block_type));
      note("offset_or_length", want.offset_or_length, got.offset_or_length);
    end
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      s_data <= '0;
      send_gap = 0;
    end else begin
      if (s_valid && s_ready) void'(stream_q.pop_front());
      if (!s_valid || s_ready) begin
        if (send_gap > 0 || stream_q.size() == 0) begin
          if (send_gap > 0) send_gap--;
          s_valid <= 1'b0;
        end else begin
          s_valid <= 1'b1;
          s_data <= stream_q[0];
          send_gap = pick_gap();
        end
      end
    end
  end

  // event monitor
  always @(posedge clk) begin
    if (rst) begin
      m_ready <= 1'b0;
      recv_gap = 0;
      hold_left = 0;
    end else begin
      if (m_valid && m_ready) check_event(m_data);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("vgm_command_stream_parser_top: mismatch");
      $finish;
    end
  end

  initial begin
    logic [7:0] code;
    logic [31:0] lim;
    int branch;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // extremes of writes and waits, short waits, a dac wait and an empty data block
    feed(CMD_AY_WRITE); feed(8'h00); feed(8'hFF);
    feed(CMD_APU_WRITE); feed(8'hFF); feed(8'h00);
    feed(CMD_WAIT_N); feed(8'h00); feed(8'h00);
    feed(CMD_WAIT_N); feed(8'hFF); feed(8'hFF);
    feed(CMD_WAIT_735);
    feed(CMD_WAIT_882);
    feed({CMD_WAIT_SHORT_HI, 4'h0});
    feed({CMD_WAIT_SHORT_HI, 4'hF});
    feed(CMD_DAC_WAIT_15);
    feed(CMD_BLOCK); feed(CMD_END); feed(8'hFF);
    feed(8'h00); feed(8'h00); feed(8'h00); feed(8'h00);

    run_phase(32'd1, 8'd0, 32'd0, 1'b1);
    run_phase(32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF, 1'b0);
    run_phase(32'($urandom), 8'($urandom_range(2, 20)),
              samples_total + 32'($urandom_range(100000, 3000000)), 1'b0);
    run_phase(32'd0, 8'($urandom_range(0, 255)), 32'd0, 1'b0);
    run_phase(32'($urandom) | 32'd1, 8'd1,
              samples_total + 32'($urandom_range(1, 5000)), 1'b0);
    run_phase(32'($urandom), 8'd0, 32'd0, 1'b0);

    // the parser can stop only once, so one stopping case per run
    settle();
    branch = $urandom_range(0, 2);
    if (branch == 0) begin
      write_reg(REG_MAX_SAMPLES, 32'd0);
      do begin
        code = 8'($urandom_range(0, 255));
      end while (cmd_len(code) >= 0);
      feed(code);
    end else if (branch == 1) begin
      write_reg(REG_MAX_SAMPLES, 32'd0);
      case ($urandom_range(0, 2))
        0: write_reg(REG_LOOP_OFFSET, 32'd0);
        1: begin
          write_reg(REG_LOOP_OFFSET, 32'($urandom) | 32'd1);
          write_reg(REG_PLAY_COUNT,
                    {24'd0, (loops_taken == 8'hFF) ? 8'hFF : loops_taken + 8'd1});
        end
        default: begin
          // loop count saturation
          write_reg(REG_LOOP_OFFSET, 32'($urandom) | 32'd1);
          write_reg(REG_PLAY_COUNT, 32'd0);
          repeat (260 - int'(loops_taken)) feed(CMD_END);
          settle();
          write_reg(REG_PLAY_COUNT, 32'hFF);
        end
      endcase
      feed(CMD_END);
    end else begin
      lim = ($urandom_range(0, 1) == 0) ? samples_total
                                         : 32'($urandom_range(1, samples_total));
      write_reg(REG_MAX_SAMPLES, lim);
      feed(8'($urandom_range(0, 255)));
    end
    quiet = 1'b0;
    repeat (20) feed(8'($urandom_range(0, 255)));

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0 && event_q.size() == 0) begin
      $display("vgm_command_stream_parser_top: match");
    end else begin
      $display("vgm_command_stream_parser_top: mismatch");
    end
    $finish;
  end

endmodule
